@@ sv/fprc_pkg.sv @@
`timescale 1ns / 1ps
// Package for the framed pixel receiver: phase codes, status codes, constants
// and the CRC-16 byte update. No dependencies.
`default_nettype none

package fprc_pkg;

	localparam int unsigned ApbAddrW = 3;
	localparam int unsigned ApbDataW = 32;

	localparam logic [ApbAddrW-1:0] RegMaxWidth  = 3'd0;
	localparam logic [ApbAddrW-1:0] RegMaxHeight = 3'd4;

	localparam logic [7:0]  SyncFirst       = 8'hA5;
	localparam logic [7:0]  SyncSecond      = 8'h5A;
	localparam logic [15:0] CrcPoly         = 16'h1021;
	localparam logic [15:0] CrcInit         = 16'hFFFF;
	localparam logic [15:0] Sync1TmoDetail  = 16'hA500;
	localparam logic [7:0]  MaxWidthReset   = 8'd80;
	localparam logic [7:0]  MaxHeightReset  = 8'd60;

	localparam logic ActByte    = 1'b0;
	localparam logic ActTimeout = 1'b1;

	localparam logic KindPixel  = 1'b0;
	localparam logic KindStatus = 1'b1;

	typedef enum logic [3:0] {
		PH_SYNC0  = 4'd0,
		PH_SYNC1  = 4'd1,
		PH_WIDTH  = 4'd2,
		PH_HEIGHT = 4'd3,
		PH_SEQ    = 4'd4,
		PH_LENLO  = 4'd5,
		PH_LENHI  = 4'd6,
		PH_PIXLO  = 4'd7,
		PH_PIXHI  = 4'd8,
		PH_CRCLO  = 4'd9,
		PH_CRCHI  = 4'd10
	} phase_t;

	typedef enum logic [2:0] {
		ST_SYNC_TMO    = 3'd0,
		ST_HDR_BAD     = 3'd1,
		ST_HDR_TMO     = 3'd2,
		ST_LEN_BAD     = 3'd3,
		ST_PAYLOAD_TMO = 3'd4,
		ST_CRC_TMO     = 3'd5,
		ST_CRC_BAD     = 3'd6,
		ST_OK          = 3'd7
	} status_t;

	// CRC-16 CCITT, MSB first, one byte
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CrcPoly;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

@@ sv/fprc_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for received bytes and for results.
// Depends on nothing.
`default_nettype none

interface fprc_rx_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] rx_byte;

	modport source (output valid, action, rx_byte, input ready);
	modport sink   (input valid, action, rx_byte, output ready);
endinterface

interface fprc_res_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [15:0] pixel_index;
	logic [15:0] pixel_value;
	logic [2:0]  frame_status;
	logic [15:0] detail_code;
	logic [7:0]  frame_seq;
	logic [7:0]  frame_width;
	logic [7:0]  frame_height;
	logic [15:0] payload_length;
	logic [15:0] crc_computed;
	logic [31:0] good_frames;
	logic [31:0] bad_frames;

	modport source (output valid, result_kind, pixel_index, pixel_value, frame_status,
		detail_code, frame_seq, frame_width, frame_height, payload_length,
		crc_computed, good_frames, bad_frames, input ready);
	modport sink (input valid, result_kind, pixel_index, pixel_value, frame_status,
		detail_code, frame_seq, frame_width, frame_height, payload_length,
		crc_computed, good_frames, bad_frames, output ready);
endinterface

`default_nettype wire

@@ sv/framed_pixel_receiver_crc16_core.sv @@
`timescale 1ns / 1ps
// Framed pixel receiver with CRC-16 check: top level.
// Depends on fprc_pkg and the channel interfaces in fprc_if.sv.
// Path: an accepted byte sits in the input register, and the result register
//   loads from it once the result register is free or its result is taken.
// Throughput: one byte or timeout per cycle unless a pending result is not taken; the CRC advances one byte per cycle.
// Reset (arst_n low, asynchronous): hunting for sync, counters and header zero,
//   limits 80 x 60, no result pending. No clearing pass.
`default_nettype none

module framed_pixel_receiver_crc16_core (
	input  wire                              clk,
	input  wire                              arst_n,
	fprc_rx_if.sink                          rx,
	fprc_res_if.source                       result,
	input  wire                              psel,
	input  wire                              penable,
	input  wire                              pwrite,
	input  wire  [fprc_pkg::ApbAddrW-1:0]    paddr,
	input  wire  [fprc_pkg::ApbDataW-1:0]    pwdata,
	output logic [fprc_pkg::ApbDataW-1:0]    prdata,
	output logic                             pready
);

	// ---------------------------------------------------------------
	// Configuration registers. Register select is paddr[2]; the low
	// address bits are not decoded.
	// ---------------------------------------------------------------
	logic [7:0] max_w_q, max_h_q;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_w_q <= fprc_pkg::MaxWidthReset;
			max_h_q <= fprc_pkg::MaxHeightReset;
		end else if (cfg_wr) begin
			if (paddr[2] == fprc_pkg::RegMaxHeight[2]) begin
				max_h_q <= pwdata[7:0];
			end else begin
				max_w_q <= pwdata[7:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == fprc_pkg::RegMaxHeight[2]) begin
			prdata = {24'h0, max_h_q};
		end else begin
			prdata = {24'h0, max_w_q};
		end
	end

	// ---------------------------------------------------------------
	// Input register. It empties whenever the result register can take
	// whatever this transaction produces, so bytes stream at one per cycle.
	// ---------------------------------------------------------------
	logic       valid_s1;
	logic       action_s1;
	logic [7:0] byte_s1;
	logic       go;      // process the registered transaction this cycle
	logic       res_valid_q;

	assign go       = valid_s1 && (!res_valid_q || result.ready);
	assign rx.ready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			action_s1 <= rx.action;
			byte_s1   <= rx.rx_byte;
		end
	end

	// ---------------------------------------------------------------
	// Receiver state
	// ---------------------------------------------------------------
	fprc_pkg::phase_t phase_q, phase_d;
	logic [15:0] skip_q, skip_d;
	logic [7:0]  hdr_w_q, hdr_w_d, hdr_h_q, hdr_h_d, hdr_seq_q, hdr_seq_d;
	logic [15:0] hdr_len_q, hdr_len_d;
	logic [7:0]  pend_w_q, pend_w_d, pend_h_q, pend_h_d, pend_seq_q, pend_seq_d;
	logic [7:0]  pend_lo_q, pend_lo_d;
	logic [7:0]  low_q, low_d;
	logic [15:0] pix_cnt_q, pix_cnt_d, pix_tot_q, pix_tot_d;
	logic [15:0] crc_q, crc_d, snap_q, snap_d, detail_q, detail_d;
	logic [31:0] ok_q, ok_d, bad_q, bad_d;

	logic        tmo;
	logic [7:0]  b;
	logic        size_bad;
	logic        len_bad;
	logic [15:0] count;     // width * height
	logic [15:0] expect_len;
	logic [15:0] new_len;
	logic [15:0] pix_cnt_inc;
	logic [15:0] rx_crc;
	logic [15:0] crc_upd;

	assign tmo         = (action_s1 == fprc_pkg::ActTimeout);
	assign b           = byte_s1;
	assign new_len     = {b, pend_lo_q};
	assign size_bad    = (pend_w_q == 8'd0) || (pend_h_q == 8'd0) ||
	                     (pend_w_q > max_w_q) || (pend_h_q > max_h_q);
	assign count       = pend_w_q * pend_h_q;
	assign expect_len  = {count[14:0], 1'b0};
	assign len_bad     = (new_len != expect_len);
	assign pix_cnt_inc = pix_cnt_q + 16'd1;
	assign rx_crc      = {b, low_q};
	// Payload CRC folds in each byte as it arrives, low byte first.
	assign crc_upd     = fprc_pkg::crc_byte(crc_q, b);

	// Next phase. Every timeout ends the attempt with a report.
	always_comb begin
		phase_d = phase_q;
		if (tmo) begin
			phase_d = fprc_pkg::PH_SYNC0;
		end else begin
			unique case (phase_q)
				fprc_pkg::PH_SYNC1: begin
					phase_d = (b == fprc_pkg::SyncSecond) ? fprc_pkg::PH_WIDTH
					                                     : fprc_pkg::PH_SYNC0;
				end
				fprc_pkg::PH_WIDTH:  phase_d = fprc_pkg::PH_HEIGHT;
				fprc_pkg::PH_HEIGHT: phase_d = fprc_pkg::PH_SEQ;
				fprc_pkg::PH_SEQ:    phase_d = fprc_pkg::PH_LENLO;
				fprc_pkg::PH_LENLO:  phase_d = fprc_pkg::PH_LENHI;
				fprc_pkg::PH_LENHI: begin
					phase_d = (size_bad || len_bad) ? fprc_pkg::PH_SYNC0
					                                : fprc_pkg::PH_PIXLO;
				end
				fprc_pkg::PH_PIXLO:  phase_d = fprc_pkg::PH_PIXHI;
				fprc_pkg::PH_PIXHI: begin
					phase_d = (pix_cnt_inc >= pix_tot_q) ? fprc_pkg::PH_CRCLO
					                                     : fprc_pkg::PH_PIXLO;
				end
				fprc_pkg::PH_CRCLO:  phase_d = fprc_pkg::PH_CRCHI;
				fprc_pkg::PH_CRCHI:  phase_d = fprc_pkg::PH_SYNC0;
				default: begin
					// sync hunt, also for any code outside the phase list
					phase_d = (b == fprc_pkg::SyncFirst) ? fprc_pkg::PH_SYNC1
					                                     : fprc_pkg::PH_SYNC0;
				end
			endcase
		end
	end

	// Datapath and result
	logic                emit_pix;
	logic                emit_rep;
	fprc_pkg::status_t   rep_status;
	logic [15:0]         rep_detail;
	logic                rep_ok;

	always_comb begin
		skip_d     = skip_q;
		hdr_w_d    = hdr_w_q;
		hdr_h_d    = hdr_h_q;
		hdr_seq_d  = hdr_seq_q;
		hdr_len_d  = hdr_len_q;
		pend_w_d   = pend_w_q;
		pend_h_d   = pend_h_q;
		pend_seq_d = pend_seq_q;
		pend_lo_d  = pend_lo_q;
		low_d      = low_q;
		pix_cnt_d  = pix_cnt_q;
		pix_tot_d  = pix_tot_q;
		crc_d      = crc_q;
		snap_d     = snap_q;
		detail_d   = detail_q;
		ok_d       = ok_q;
		bad_d      = bad_q;
		emit_pix   = 1'b0;
		emit_rep   = 1'b0;
		rep_status = fprc_pkg::ST_SYNC_TMO;
		rep_detail = 16'h0;
		rep_ok     = 1'b0;

		unique case (phase_q)
			fprc_pkg::PH_SYNC1: begin
				if (tmo) begin
					emit_rep   = 1'b1;
					rep_detail = fprc_pkg::Sync1TmoDetail;
				end else if (b == fprc_pkg::SyncSecond) begin
					detail_d = skip_q;
				end else begin
					skip_d = skip_q + 16'd1;
				end
			end
			fprc_pkg::PH_WIDTH, fprc_pkg::PH_HEIGHT, fprc_pkg::PH_SEQ,
			fprc_pkg::PH_LENLO: begin
				if (tmo) begin
					emit_rep   = 1'b1;
					rep_status = fprc_pkg::ST_HDR_TMO;
					rep_detail = {12'h0, phase_q} - 16'd1;
				end else begin
					unique case (phase_q)
						fprc_pkg::PH_WIDTH:  pend_w_d   = b;
						fprc_pkg::PH_HEIGHT: pend_h_d   = b;
						fprc_pkg::PH_SEQ:    pend_seq_d = b;
						default:             pend_lo_d  = b;
					endcase
				end
			end
			fprc_pkg::PH_LENHI: begin
				if (tmo) begin
					emit_rep   = 1'b1;
					rep_status = fprc_pkg::ST_HDR_TMO;
					rep_detail = 16'd5;
				end else begin
					hdr_w_d   = pend_w_q;
					hdr_h_d   = pend_h_q;
					hdr_seq_d = pend_seq_q;
					hdr_len_d = new_len;
					snap_d    = 16'h0;
					detail_d  = 16'h0;
					if (size_bad) begin
						emit_rep   = 1'b1;
						rep_status = fprc_pkg::ST_HDR_BAD;
						rep_detail = {pend_w_q, pend_h_q};
					end else if (len_bad) begin
						emit_rep   = 1'b1;
						rep_status = fprc_pkg::ST_LEN_BAD;
						rep_detail = expect_len;
					end else begin
						pix_tot_d = count;
						pix_cnt_d = 16'h0;
						crc_d     = fprc_pkg::CrcInit;
					end
				end
			end
			fprc_pkg::PH_PIXLO: begin
				if (tmo) begin
					emit_rep   = 1'b1;
					rep_status = fprc_pkg::ST_PAYLOAD_TMO;
					rep_detail = {pix_cnt_q[14:0], 1'b0};
				end else begin
					low_d = b;
					crc_d = crc_upd;
				end
			end
			fprc_pkg::PH_PIXHI: begin
				if (tmo) begin
					emit_rep   = 1'b1;
					rep_status = fprc_pkg::ST_PAYLOAD_TMO;
					rep_detail = {pix_cnt_q[14:0], 1'b1};
				end else begin
					emit_pix  = 1'b1;
					crc_d     = crc_upd;
					pix_cnt_d = pix_cnt_inc;
				end
			end
			fprc_pkg::PH_CRCLO: begin
				if (tmo) begin
					emit_rep   = 1'b1;
					rep_status = fprc_pkg::ST_CRC_TMO;
					rep_detail = 16'd0;
				end else begin
					low_d = b;
				end
			end
			fprc_pkg::PH_CRCHI: begin
				emit_rep = 1'b1;
				if (tmo) begin
					rep_status = fprc_pkg::ST_CRC_TMO;
					rep_detail = 16'd1;
				end else begin
					snap_d = crc_q;
					if (rx_crc != crc_q) begin
						rep_status = fprc_pkg::ST_CRC_BAD;
						rep_detail = rx_crc ^ crc_q;
					end else begin
						rep_status = fprc_pkg::ST_OK;
						rep_ok     = 1'b1;
					end
				end
			end
			default: begin
				if (tmo) begin
					emit_rep   = 1'b1;
					rep_detail = detail_q;
				end else if (b != fprc_pkg::SyncFirst) begin
					skip_d = skip_q + 16'd1;
				end
			end
		endcase

		if (emit_rep) begin
			detail_d = rep_detail;
			skip_d   = 16'h0;
			if (rep_ok) begin
				ok_d = ok_q + 32'd1;
			end else begin
				bad_d = bad_q + 32'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= fprc_pkg::PH_SYNC0;
			skip_q     <= 16'h0;
			hdr_w_q    <= 8'h0;
			hdr_h_q    <= 8'h0;
			hdr_seq_q  <= 8'h0;
			hdr_len_q  <= 16'h0;
			pend_w_q   <= 8'h0;
			pend_h_q   <= 8'h0;
			pend_seq_q <= 8'h0;
			pend_lo_q  <= 8'h0;
			low_q      <= 8'h0;
			pix_cnt_q  <= 16'h0;
			pix_tot_q  <= 16'h0;
			crc_q      <= fprc_pkg::CrcInit;
			snap_q     <= 16'h0;
			detail_q   <= 16'h0;
			ok_q       <= 32'h0;
			bad_q      <= 32'h0;
		end else if (go) begin
			phase_q    <= phase_d;
			skip_q     <= skip_d;
			hdr_w_q    <= hdr_w_d;
			hdr_h_q    <= hdr_h_d;
			hdr_seq_q  <= hdr_seq_d;
			hdr_len_q  <= hdr_len_d;
			pend_w_q   <= pend_w_d;
			pend_h_q   <= pend_h_d;
			pend_seq_q <= pend_seq_d;
			pend_lo_q  <= pend_lo_d;
			low_q      <= low_d;
			pix_cnt_q  <= pix_cnt_d;
			pix_tot_q  <= pix_tot_d;
			crc_q      <= crc_d;
			snap_q     <= snap_d;
			detail_q   <= detail_d;
			ok_q       <= ok_d;
			bad_q      <= bad_d;
		end
	end

	// ---------------------------------------------------------------
	// Result register. A pixel carries zeros in all report fields; a
	// report shows header and counters as they stand after this byte.
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (go) begin
			res_valid_q <= emit_pix || emit_rep;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	logic        kind_q;
	logic [15:0] pidx_q, pval_q, det_out_q, len_out_q, crc_out_q;
	logic [2:0]  stat_q;
	logic [7:0]  seq_out_q, w_out_q, h_out_q;
	logic [31:0] good_out_q, bad_out_q;

	always_ff @(posedge clk) begin
		if (go) begin
			if (emit_pix) begin
				kind_q     <= fprc_pkg::KindPixel;
				pidx_q     <= pix_cnt_q;
				pval_q     <= {b, low_q};
				stat_q     <= 3'd0;
				det_out_q  <= 16'h0;
				seq_out_q  <= 8'h0;
				w_out_q    <= 8'h0;
				h_out_q    <= 8'h0;
				len_out_q  <= 16'h0;
				crc_out_q  <= 16'h0;
				good_out_q <= 32'h0;
				bad_out_q  <= 32'h0;
			end else begin
				kind_q     <= fprc_pkg::KindStatus;
				pidx_q     <= 16'h0;
				pval_q     <= 16'h0;
				stat_q     <= rep_status;
				det_out_q  <= detail_d;
				seq_out_q  <= hdr_seq_d;
				w_out_q    <= hdr_w_d;
				h_out_q    <= hdr_h_d;
				len_out_q  <= hdr_len_d;
				crc_out_q  <= snap_d;
				good_out_q <= ok_d;
				bad_out_q  <= bad_d;
			end
		end
	end

	assign result.valid          = res_valid_q;
	assign result.result_kind    = kind_q;
	assign result.pixel_index    = pidx_q;
	assign result.pixel_value    = pval_q;
	assign result.frame_status   = stat_q;
	assign result.detail_code    = det_out_q;
	assign result.frame_seq      = seq_out_q;
	assign result.frame_width    = w_out_q;
	assign result.frame_height   = h_out_q;
	assign result.payload_length = len_out_q;
	assign result.crc_computed   = crc_out_q;
	assign result.good_frames    = good_out_q;
	assign result.bad_frames     = bad_out_q;

endmodule

`default_nettype wire

@@ sv/fprc_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks on the framed pixel receiver, and their bind.
// Depends on fprc_pkg and framed_pixel_receiver_crc16_core.
`default_nettype none

module fprc_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        res_valid,
	input wire        res_ready,
	input wire        result_kind,
	input wire [15:0] pixel_index,
	input wire [15:0] pixel_value,
	input wire [2:0]  frame_status,
	input wire [15:0] detail_code,
	input wire [31:0] good_frames,
	input wire [31:0] bad_frames
);

	// stalled result holds valid, index, value, detail and kind
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(pixel_index) &&
		$stable(pixel_value) && $stable(detail_code) && $stable(result_kind))
		else $error("result changed while stalled");

	a_pix_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && result_kind == fprc_pkg::KindPixel |->
		frame_status == 3'd0 && detail_code == 16'h0 &&
		good_frames == 32'h0 && bad_frames == 32'h0)
		else $error("pixel carries report fields");

	a_rep_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && result_kind == fprc_pkg::KindStatus |->
		pixel_index == 16'h0 && pixel_value == 16'h0)
		else $error("report carries pixel fields");

	a_ok_detail: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && result_kind == fprc_pkg::KindStatus &&
		frame_status == fprc_pkg::ST_OK |-> detail_code == 16'h0 && good_frames != 32'h0)
		else $error("ok report with detail or without count");

	a_crc_bad_detail: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && result_kind == fprc_pkg::KindStatus &&
		frame_status == fprc_pkg::ST_CRC_BAD |-> detail_code != 16'h0)
		else $error("crc mismatch with zero difference");

endmodule

bind framed_pixel_receiver_crc16_core fprc_checker u_fprc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (result.valid),
	.res_ready    (result.ready),
	.result_kind  (result.result_kind),
	.pixel_index  (result.pixel_index),
	.pixel_value  (result.pixel_value),
	.frame_status (result.frame_status),
	.detail_code  (result.detail_code),
	.good_frames  (result.good_frames),
	.bad_frames   (result.bad_frames)
);

`default_nettype wire
